[rtl/phd_pkg.sv]
// shared types, constants and helpers for the page-hinkley drift detector
package phd_pkg;

    // field and state widths
    localparam int SAMPLE_BITS    = 16;
    localparam int COUNT_BITS     = 32;
    localparam int SUM_BITS       = 48;
    localparam int STAT_BITS      = 32;
    localparam int DELTA_BITS     = 16;
    localparam int WARM_BITS      = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    // divider sizing: one quotient bit per step
    localparam int DIV_STEPS    = SUM_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

    // statistic arithmetic runs three bits wider to hold sign and carry
    localparam int STAT_EXT = STAT_BITS + 3;

    // register reset values
    localparam logic [DELTA_BITS-1:0] DELTA_RESET     = '0;
    localparam logic [STAT_BITS-1:0]  THRESHOLD_RESET = STAT_BITS'(204800);
    localparam logic [WARM_BITS-1:0]  WARM_RESET      = WARM_BITS'(1);

    // mean limits as quotient magnitudes
    localparam logic [SUM_BITS-1:0] MEAN_NEG_LIMIT = SUM_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [SUM_BITS-1:0] MEAN_POS_LIMIT = MEAN_NEG_LIMIT - SUM_BITS'(1);

    // register map
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ALLOWANCE = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_WARMUP    = 2'd2
    } cfg_reg_t;

    // input action codes
    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_START,
        ST_DIVIDE,
        ST_UPDATE,
        ST_EMIT
    } phd_state_t;

    // sequencer strobes
    typedef struct packed {
        logic item_ready;
        logic accum;
        logic update;
        logic load;
    } phd_ctrl_t;

    // divider control and status
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // one result word
    typedef struct packed {
        logic                          up_alarm;
        logic                          down_alarm;
        logic [STAT_BITS-1:0]          up_magnitude;
        logic [STAT_BITS-1:0]          down_magnitude;
        logic signed [SAMPLE_BITS-1:0] sample_mean;
        logic [STAT_BITS-1:0]          up_statistic;
        logic [STAT_BITS-1:0]          down_statistic;
        logic [STAT_BITS-1:0]          up_alarm_total;
        logic [STAT_BITS-1:0]          down_alarm_total;
        logic [STAT_BITS-1:0]          record_total;
    } result_t;

    // saturating increment of a 32-bit counter
    function automatic logic [STAT_BITS-1:0] sat_inc(input logic [STAT_BITS-1:0] c);
        logic [STAT_BITS-1:0] r;
        r = (c == '1) ? c : c + STAT_BITS'(1);
        return r;
    endfunction

    // clamp a widened statistic to [0, 2^32-1]
    function automatic logic [STAT_BITS-1:0] clamp_stat(input logic signed [STAT_EXT-1:0] v);
        logic [STAT_BITS-1:0] r;
        if (v[STAT_EXT-1])
            r = '0;
        else if (v[STAT_EXT-2:STAT_BITS] != '0)
            r = '1;
        else
            r = v[STAT_BITS-1:0];
        return r;
    endfunction

endpackage

[rtl/phd_if.sv]
// channel interfaces: sample words, result words and register writes
interface phd_item_if import phd_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output action, output sample, input ready);
    modport sink (input valid, input action, input sample, output ready);
endinterface

interface phd_result_if import phd_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          up_alarm;
    logic                          down_alarm;
    logic [STAT_BITS-1:0]          up_magnitude;
    logic [STAT_BITS-1:0]          down_magnitude;
    logic signed [SAMPLE_BITS-1:0] sample_mean;
    logic [STAT_BITS-1:0]          up_statistic;
    logic [STAT_BITS-1:0]          down_statistic;
    logic [STAT_BITS-1:0]          up_alarm_total;
    logic [STAT_BITS-1:0]          down_alarm_total;
    logic [STAT_BITS-1:0]          record_total;

    modport source (
        output valid, output up_alarm, output down_alarm, output up_magnitude,
        output down_magnitude, output sample_mean, output up_statistic,
        output down_statistic, output up_alarm_total, output down_alarm_total,
        output record_total, input ready
    );
    modport sink (
        input valid, input up_alarm, input down_alarm, input up_magnitude,
        input down_magnitude, input sample_mean, input up_statistic,
        input down_statistic, input up_alarm_total, input down_alarm_total,
        input record_total, output ready
    );
endinterface

interface phd_cfg_if import phd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/page_hinkley_drift_detector.sv]
// two-sided page-hinkley drift detector around a single iterative divider
//
//  channel  direction  handshake     payload
//  cfg      in         valid/ready   index, data
//  item     in         valid/ready   action, sample
//  result   out        valid/ready   alarms, magnitudes, mean, statistics, totals
//
// a recorded sample passes through accum, start, divide and update before emit loads
// the output register; divide waits on the 48-step radix-2 divider that forms the
// running mean. a clear goes from idle straight to emit. the next word is taken in idle.
// rst_n resets config, statistics, counters and control, not payload; no clearing sweep.
// the finished word sits in an output register, so the next sample is taken
// while the result still waits; a stalled result holds the sequencer in emit.
// register writes are always taken; mapped ones clear the running statistics.
module page_hinkley_drift_detector import phd_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    phd_cfg_if.sink         cfg,
    phd_item_if.sink        item,
    phd_result_if.source    result
);

    phd_state_t  state_reg, state_next;
    phd_ctrl_t   ctrl;
    div_ctrl_t   div_ctrl;
    div_status_t div_status;
    logic [SUM_BITS-1:0] quotient;

    // configuration registers
    logic [DELTA_BITS-1:0] allowance_reg, allowance_next;
    logic [STAT_BITS-1:0]  threshold_reg, threshold_next;
    logic [WARM_BITS-1:0]  warmup_reg, warmup_next;

    // detector state
    logic [COUNT_BITS-1:0]      count_reg, count_next;
    logic signed [SUM_BITS-1:0] sum_reg, sum_next;
    logic [STAT_BITS-1:0]       up_acc_reg, up_acc_next;
    logic [STAT_BITS-1:0]       dn_acc_reg, dn_acc_next;
    logic [STAT_BITS-1:0]       up_tot_reg, up_tot_next;
    logic [STAT_BITS-1:0]       dn_tot_reg, dn_tot_next;
    logic [STAT_BITS-1:0]       rec_tot_reg, rec_tot_next;

    // per-sample staging
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic signed [SAMPLE_BITS-1:0] mean_reg, mean_next;
    logic                          up_fire_reg, up_fire_next;
    logic                          dn_fire_reg, dn_fire_next;
    logic [STAT_BITS-1:0]          up_mag_reg, up_mag_next;
    logic [STAT_BITS-1:0]          dn_mag_reg, dn_mag_next;

    // output register
    logic    out_valid_reg, out_valid_next;
    result_t res_reg, res_next;

    logic item_fire;
    logic cfg_fire;
    logic cfg_hit;
    logic out_free;

    logic signed [SUM_BITS:0]      sum_wide;
    logic signed [SUM_BITS-1:0]    sum_sat;
    logic [SUM_BITS-1:0]           sum_mag;
    logic signed [SAMPLE_BITS-1:0] mean_val;
    logic signed [STAT_EXT-1:0]    delta_ext;
    logic signed [STAT_EXT-1:0]    up_wide;
    logic signed [STAT_EXT-1:0]    dn_wide;
    logic [STAT_BITS-1:0]          up_clamped;
    logic [STAT_BITS-1:0]          dn_clamped;
    logic [WARM_BITS-1:0]          warm;
    logic                          warm_ok;
    logic                          up_fire;
    logic                          dn_fire;

    assign item_fire = item.valid && item.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign cfg_hit   = cfg_fire && (cfg.index == REG_ALLOWANCE ||
                                    cfg.index == REG_THRESHOLD ||
                                    cfg.index == REG_WARMUP);
    assign out_free  = !out_valid_reg || result.ready;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                    state_next = (item.action == ACT_CLEAR) ? ST_EMIT : ST_ACCUM;
            end
            ST_ACCUM:  state_next = ST_START;
            ST_START:  state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (div_status.done)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ctrl           = '0;
        div_ctrl.start = 1'b0;
        unique case (state_reg)
            ST_IDLE:   ctrl.item_ready = 1'b1;
            ST_ACCUM:  ctrl.accum = 1'b1;
            ST_START:  div_ctrl.start = 1'b1;
            ST_DIVIDE: ;
            ST_UPDATE: ctrl.update = 1'b1;
            ST_EMIT:   ctrl.load = out_free;
            default:   ;
        endcase
    end

    assign item.ready = ctrl.item_ready;
    assign cfg.ready  = 1'b1;

    // single divider for the running mean
    assign sum_mag = sum_reg[SUM_BITS-1] ? (~sum_reg + SUM_BITS'(1)) : sum_reg;

    phd_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (sum_mag),
        .divisor  (count_reg),
        .status   (div_status),
        .quotient (quotient)
    );

    // saturating running sum
    always_comb
    begin
        sum_wide = $signed({sum_reg[SUM_BITS-1], sum_reg}) + (SUM_BITS+1)'(sample_reg);
        if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1])
            sum_sat = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                         : {1'b0, {(SUM_BITS-1){1'b1}}};
        else
            sum_sat = sum_wide[SUM_BITS-1:0];
    end

    // signed mean from the quotient, clamped to the sample range
    always_comb
    begin
        if (!sum_reg[SUM_BITS-1])
            mean_val = (quotient > MEAN_POS_LIMIT) ? SAMPLE_BITS'(MEAN_POS_LIMIT)
                                                   : SAMPLE_BITS'(quotient);
        else if (quotient > MEAN_NEG_LIMIT)
            mean_val = SAMPLE_BITS'(MEAN_NEG_LIMIT);
        else
            mean_val = SAMPLE_BITS'(~quotient + SUM_BITS'(1));
    end

    // cumulative statistics and alarm tests
    always_comb
    begin
        delta_ext  = STAT_EXT'($signed({1'b0, allowance_reg}));
        up_wide    = $signed({3'b000, up_acc_reg}) + STAT_EXT'(sample_reg)
                     - STAT_EXT'(mean_val) - delta_ext;
        dn_wide    = $signed({3'b000, dn_acc_reg}) + STAT_EXT'(mean_val)
                     - STAT_EXT'(sample_reg) - delta_ext;
        up_clamped = clamp_stat(up_wide);
        dn_clamped = clamp_stat(dn_wide);
        warm       = (warmup_reg == '0) ? WARM_BITS'(1) : warmup_reg;
        warm_ok    = count_reg >= COUNT_BITS'(warm);
        up_fire    = warm_ok && (up_clamped > threshold_reg);
        dn_fire    = warm_ok && (dn_clamped > threshold_reg);
    end

    // state updates
    always_comb
    begin
        allowance_next = allowance_reg;
        threshold_next = threshold_reg;
        warmup_next    = warmup_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        up_acc_next    = up_acc_reg;
        dn_acc_next    = dn_acc_reg;
        up_tot_next    = up_tot_reg;
        dn_tot_next    = dn_tot_reg;
        rec_tot_next   = rec_tot_reg;
        sample_next    = sample_reg;
        mean_next      = mean_reg;
        up_fire_next   = up_fire_reg;
        dn_fire_next   = dn_fire_reg;
        up_mag_next    = up_mag_reg;
        dn_mag_next    = dn_mag_reg;

        if (item_fire)
        begin
            sample_next = item.sample;
            if (item.action == ACT_CLEAR)
            begin
                count_next   = '0;
                sum_next     = '0;
                up_acc_next  = '0;
                dn_acc_next  = '0;
                up_tot_next  = '0;
                dn_tot_next  = '0;
                rec_tot_next = '0;
                mean_next    = '0;
                up_fire_next = 1'b0;
                dn_fire_next = 1'b0;
                up_mag_next  = '0;
                dn_mag_next  = '0;
            end
        end

        if (ctrl.accum)
        begin
            count_next   = (count_reg == '1) ? count_reg : count_reg + COUNT_BITS'(1);
            rec_tot_next = sat_inc(rec_tot_reg);
            sum_next     = sum_sat;
        end

        if (ctrl.update)
        begin
            mean_next    = mean_val;
            up_fire_next = up_fire;
            dn_fire_next = dn_fire;
            up_mag_next  = up_fire ? up_clamped : '0;
            dn_mag_next  = dn_fire ? dn_clamped : '0;
            up_acc_next  = up_fire ? '0 : up_clamped;
            dn_acc_next  = dn_fire ? '0 : dn_clamped;
            if (up_fire)
                up_tot_next = sat_inc(up_tot_reg);
            if (dn_fire)
                dn_tot_next = sat_inc(dn_tot_reg);
        end

        // writes to a mapped register restart the running statistics
        if (cfg_fire)
        begin
            unique case (cfg.index)
                REG_ALLOWANCE: allowance_next = cfg.data[DELTA_BITS-1:0];
                REG_THRESHOLD: threshold_next = cfg.data[STAT_BITS-1:0];
                REG_WARMUP:    warmup_next    = cfg.data[WARM_BITS-1:0];
                default:       ;
            endcase
        end
        if (cfg_hit)
        begin
            count_next  = '0;
            sum_next    = '0;
            up_acc_next = '0;
            dn_acc_next = '0;
        end
    end

    // result word assembly
    always_comb
    begin
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (result.valid && result.ready)
            out_valid_next = 1'b0;
        if (ctrl.load)
        begin
            out_valid_next            = 1'b1;
            res_next.up_alarm         = up_fire_reg;
            res_next.down_alarm       = dn_fire_reg;
            res_next.up_magnitude     = up_mag_reg;
            res_next.down_magnitude   = dn_mag_reg;
            res_next.sample_mean      = mean_reg;
            res_next.up_statistic     = up_acc_reg;
            res_next.down_statistic   = dn_acc_reg;
            res_next.up_alarm_total   = up_tot_reg;
            res_next.down_alarm_total = dn_tot_reg;
            res_next.record_total     = rec_tot_reg;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            allowance_reg <= DELTA_RESET;
            threshold_reg <= THRESHOLD_RESET;
            warmup_reg    <= WARM_RESET;
            count_reg     <= '0;
            sum_reg       <= '0;
            up_acc_reg    <= '0;
            dn_acc_reg    <= '0;
            up_tot_reg    <= '0;
            dn_tot_reg    <= '0;
            rec_tot_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            allowance_reg <= allowance_next;
            threshold_reg <= threshold_next;
            warmup_reg    <= warmup_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            up_acc_reg    <= up_acc_next;
            dn_acc_reg    <= dn_acc_next;
            up_tot_reg    <= up_tot_next;
            dn_tot_reg    <= dn_tot_next;
            rec_tot_reg   <= rec_tot_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        mean_reg    <= mean_next;
        up_fire_reg <= up_fire_next;
        dn_fire_reg <= dn_fire_next;
        up_mag_reg  <= up_mag_next;
        dn_mag_reg  <= dn_mag_next;
        res_reg     <= res_next;
    end

    // result port
    assign result.valid            = out_valid_reg;
    assign result.up_alarm         = res_reg.up_alarm;
    assign result.down_alarm       = res_reg.down_alarm;
    assign result.up_magnitude     = res_reg.up_magnitude;
    assign result.down_magnitude   = res_reg.down_magnitude;
    assign result.sample_mean      = res_reg.sample_mean;
    assign result.up_statistic     = res_reg.up_statistic;
    assign result.down_statistic   = res_reg.down_statistic;
    assign result.up_alarm_total   = res_reg.up_alarm_total;
    assign result.down_alarm_total = res_reg.down_alarm_total;
    assign result.record_total     = res_reg.record_total;

    // checks
    a_up_alarm_word: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.up_alarm) |->
            (result.up_magnitude != '0 && result.up_statistic == '0))
        else $error("upward alarm word inconsistent");
    a_down_alarm_word: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.down_alarm) |->
            (result.down_magnitude != '0 && result.down_statistic == '0))
        else $error("downward alarm word inconsistent");
    a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !div_status.busy)
        else $error("sample taken while divider busy");
    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide step");

endmodule

[rtl/phd_divider.sv]
// radix-2 restoring divider, one quotient bit per cycle
module phd_divider import phd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  div_ctrl_t             ctrl,
    input  logic [SUM_BITS-1:0]   dividend,
    input  logic [COUNT_BITS-1:0] divisor,
    output div_status_t           status,
    output logic [SUM_BITS-1:0]   quotient
);

    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [SUM_BITS-1:0]     quo_reg, quo_next;
    logic [COUNT_BITS-1:0]   rem_reg, rem_next;
    logic [COUNT_BITS-1:0]   dsr_reg, dsr_next;

    logic [COUNT_BITS:0]     shifted;
    logic [COUNT_BITS:0]     trial;

    // one shift-subtract step
    assign shifted = {rem_reg, quo_reg[SUM_BITS-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (ctrl.start)
        begin
            cnt_next  = DIV_CNT_BITS'(DIV_STEPS);
            busy_next = 1'b1;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial[COUNT_BITS])
            begin
                rem_next = shifted[COUNT_BITS-1:0];
                quo_next = {quo_reg[SUM_BITS-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[COUNT_BITS-1:0];
                quo_next = {quo_reg[SUM_BITS-2:0], 1'b1};
            end
            cnt_next = cnt_reg - DIV_CNT_BITS'(1);
            if (cnt_reg == DIV_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

    // checks
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a finished run");
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (cnt_reg == '0))
        else $error("divider step count left over");

endmodule

[tb/sv/page_hinkley_drift_detector_tb.sv]
// self-checking testbench for the page-hinkley drift detector
module page_hinkley_drift_detector_tb;
    import phd_pkg::*;

    // write index that maps to no register
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    // running sum and mean limits
    localparam longint SUM_TOP     = (longint'(1) << (SUM_BITS - 1)) - 1;
    localparam longint SUM_BOTTOM  = -SUM_TOP - 1;
    localparam longint MEAN_TOP    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint MEAN_BOTTOM = -MEAN_TOP - 1;

    logic clk = 1'b0;
    logic rst_n;

    phd_cfg_if    cfg_ch ();
    phd_item_if   item_ch ();
    phd_result_if result_ch ();

    page_hinkley_drift_detector i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (result_ch)
    );

    // detector settings and statistics as the block should hold them
    logic [DELTA_BITS-1:0] drift_allow;
    logic [STAT_BITS-1:0]  alarm_level;
    logic [WARM_BITS-1:0]  warmup_len;
    logic [COUNT_BITS-1:0] sample_cnt;
    longint                sample_sum;
    logic [STAT_BITS-1:0]  up_stat;
    logic [STAT_BITS-1:0]  down_stat;
    logic [STAT_BITS-1:0]  up_alarms;
    logic [STAT_BITS-1:0]  down_alarms;
    logic [STAT_BITS-1:0]  records;

    result_t expected_words[$];

    int  mismatches    = 0;
    int  words_sent    = 0;
    int  words_checked = 0;
    int  reg_writes    = 0;
    int  settings_used = 0;
    int  up_fired      = 0;
    int  down_fired    = 0;
    bit  quiet_run     = 1'b0;
    int  stall_left    = 0;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // clamp a widened statistic into 32 unsigned bits
    function automatic logic [STAT_BITS-1:0] sat_stat(input longint v);
        if (v < 0)
            return '0;
        if (v > longint'(32'hFFFF_FFFF))
            return '1;
        return v[STAT_BITS-1:0];
    endfunction

    // drop the running statistics, keep the totals
    function automatic void restart_stats();
        sample_cnt = '0;
        sample_sum = 0;
        up_stat    = '0;
        down_stat  = '0;
    endfunction

    // register write as the block should apply it
    function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            REG_ALLOWANCE: drift_allow = value[DELTA_BITS-1:0];
            REG_THRESHOLD: alarm_level = value[STAT_BITS-1:0];
            REG_WARMUP:    warmup_len  = value[WARM_BITS-1:0];
            default:       return;
        endcase
        restart_stats();
    endfunction

    // expected result word for one accepted sample word
    function automatic result_t predict_word(input logic act,
                                             input logic signed [SAMPLE_BITS-1:0] smp);
        result_t r;
        longint x, s, mean, up, dn, dly;
        longint unsigned mag, q;
        logic [COUNT_BITS-1:0] warm_need;
        r = '0;
        if (act == ACT_CLEAR)
        begin
            restart_stats();
            up_alarms   = '0;
            down_alarms = '0;
            records     = '0;
            return r;
        end
        x = smp;
        if (records != '1)
            records++;
        if (sample_cnt != '1)
            sample_cnt++;
        s = sample_sum + x;
        if (s > SUM_TOP)
            s = SUM_TOP;
        if (s < SUM_BOTTOM)
            s = SUM_BOTTOM;
        sample_sum = s;

        // truncated mean
        mag  = (s < 0) ? -s : s;
        q    = mag / sample_cnt;
        mean = (s < 0) ? -longint'(q) : longint'(q);
        if (mean > MEAN_TOP)
            mean = MEAN_TOP;
        if (mean < MEAN_BOTTOM)
            mean = MEAN_BOTTOM;

        // both cumulative statistics
        dly = drift_allow;
        up  = up_stat;
        dn  = down_stat;
        up_stat   = sat_stat(up + x - mean - dly);
        down_stat = sat_stat(dn + mean - x - dly);

        // alarms once warmed up
        warm_need = (warmup_len == '0) ? COUNT_BITS'(1) : COUNT_BITS'(warmup_len);
        if (sample_cnt >= warm_need)
        begin
            if (up_stat > alarm_level)
            begin
                r.up_alarm     = 1'b1;
                r.up_magnitude = up_stat;
                up_stat        = '0;
                if (up_alarms != '1)
                    up_alarms++;
            end
            if (down_stat > alarm_level)
            begin
                r.down_alarm     = 1'b1;
                r.down_magnitude = down_stat;
                down_stat        = '0;
                if (down_alarms != '1)
                    down_alarms++;
            end
        end
        r.sample_mean      = mean[SAMPLE_BITS-1:0];
        r.up_statistic     = up_stat;
        r.down_statistic   = down_stat;
        r.up_alarm_total   = up_alarms;
        r.down_alarm_total = down_alarms;
        r.record_total     = records;
        return r;
    endfunction

    // one field of a result word
    function automatic void compare_field(input string fname,
                                          input logic [STAT_BITS-1:0] want,
                                          input logic [STAT_BITS-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
            mismatches++;
        end
    endfunction

    // result side: random stalls, occasionally a long one
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left      <= stall_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (!quiet_run && $urandom_range(99) < 2)
        begin
            stall_left      <= ($urandom_range(49) == 0) ? 120 : $urandom_range(0, 5);
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (result_ch.valid && result_ch.ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: result word with none expected, got up_stat %h down_stat %h",
                         $time, result_ch.up_statistic, result_ch.down_statistic);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                words_checked++;
                up_fired   += want.up_alarm;
                down_fired += want.down_alarm;
                compare_field("up_alarm", STAT_BITS'(want.up_alarm),
                              STAT_BITS'(result_ch.up_alarm));
                compare_field("down_alarm", STAT_BITS'(want.down_alarm),
                              STAT_BITS'(result_ch.down_alarm));
                compare_field("up_magnitude", want.up_magnitude, result_ch.up_magnitude);
                compare_field("down_magnitude", want.down_magnitude,
                              result_ch.down_magnitude);
                compare_field("sample_mean", STAT_BITS'(want.sample_mean),
                              STAT_BITS'(result_ch.sample_mean));
                compare_field("up_statistic", want.up_statistic, result_ch.up_statistic);
                compare_field("down_statistic", want.down_statistic,
                              result_ch.down_statistic);
                compare_field("up_alarm_total", want.up_alarm_total,
                              result_ch.up_alarm_total);
                compare_field("down_alarm_total", want.down_alarm_total,
                              result_ch.down_alarm_total);
                compare_field("record_total", want.record_total, result_ch.record_total);
            end
        end
    end

    // send one sample word, leaving valid up for a following word
    task automatic send_word(input logic act, input logic signed [SAMPLE_BITS-1:0] smp);
        if (!quiet_run && $urandom_range(99) < 9)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 64)) @(posedge clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.action <= act;
        item_ch.sample <= smp;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        expected_words.push_back(predict_word(act, smp));
        words_sent++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one register write, valid left up for a following write
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        apply_reg(idx, value);
        reg_writes++;
    endtask

    // idle the block, then load all three registers, with junk in unused allowance and warmup bits
    task automatic set_detector(input logic [DELTA_BITS-1:0] allow,
                                input logic [STAT_BITS-1:0] thr,
                                input logic [WARM_BITS-1:0] warm);
        drain();
        write_reg(REG_ALLOWANCE, {16'($urandom), allow});
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_WARMUP, {16'($urandom), warm});
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // full-scale samples and a clear at reset settings
    task automatic test_sample_extremes();
        send_word(ACT_RECORD, 16'sh7FFF);
        send_word(ACT_RECORD, -16'sh8000);
        send_word(ACT_RECORD, 16'sh0000);
        send_word(ACT_RECORD, -16'sh0001);
        send_word(ACT_RECORD, 16'sh0001);
        send_word(ACT_CLEAR, 16'sh5A5A);
        send_word(ACT_RECORD, 16'sh1234);
    endtask

    // a level step up and then down fires both alarms
    task automatic test_step_alarms();
        set_detector(16'h0000, 32'd40960, 16'h0000);
        repeat (2) send_word(ACT_RECORD, -16'sh8000);
        repeat (6) send_word(ACT_RECORD, 16'sh7FFF);
        repeat (6) send_word(ACT_RECORD, -16'sh8000);
    endtask

    // a write to an unused index must leave the statistics running
    task automatic test_unused_register();
        drain();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        cfg_ch.valid <= 1'b0;
        send_word(ACT_RECORD, 16'sh7FFF);
        send_word(ACT_RECORD, 16'sh2000);
    endtask

    // piecewise-level streams with noise, stray words and the odd clear
    task automatic run_drift_phase(input int n_words, input bit hold_midway);
        logic signed [SAMPLE_BITS-1:0] level;
        int run_left, spread, pick, v;
        run_left = 0;
        level    = '0;
        spread   = 0;
        for (int k = 0; k < n_words; k++)
        begin
            if (run_left == 0)
            begin
                level    = $signed(16'($urandom)) >>> $urandom_range(0, 5);
                spread   = 1 << $urandom_range(0, 11);
                run_left = $urandom_range(4, 60);
            end
            run_left--;
            if (hold_midway && k == n_words / 2)
                drain();
            pick = $urandom_range(99);
            if (pick < 2)
                send_word(ACT_CLEAR, 16'($urandom));
            else if (pick < 5)
                send_word(ACT_RECORD, 16'($urandom));
            else
            begin
                v = int'(level) + int'($urandom_range(0, 2 * spread)) - spread;
                if (v > MEAN_TOP)
                    v = MEAN_TOP;
                if (v < MEAN_BOTTOM)
                    v = MEAN_BOTTOM;
                send_word(ACT_RECORD, SAMPLE_BITS'(v));
            end
        end
    endtask

    // random streams over extreme and random settings
    task automatic test_random_streams();
        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: set_detector(16'h0000, 32'h0000_0000, 16'h0000);
                1: set_detector(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
                2: set_detector(16'($urandom_range(0, 512)), 32'hFFFF_FFFF, 16'h0001);
                4: set_detector(16'($urandom_range(0, 4096)), 32'($urandom), 16'h0000);
                default: set_detector(16'($urandom_range(0, 2048)),
                                      32'($urandom_range(0, 400000)),
                                      16'($urandom_range(0, 40)));
            endcase
            quiet_run = (p == 2);
            run_drift_phase(200, p == 3);
        end
        quiet_run = 1'b0;
    endtask

    // stimulus sequence
    initial
    begin
        rst_n          = 1'b0;
        item_ch.valid  = 1'b0;
        item_ch.action = ACT_RECORD;
        item_ch.sample = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = REG_ALLOWANCE;
        cfg_ch.data    = '0;
        result_ch.ready = 1'b0;
        drift_allow = DELTA_RESET;
        alarm_level = THRESHOLD_RESET;
        warmup_len  = WARM_RESET;
        restart_stats();
        up_alarms   = '0;
        down_alarms = '0;
        records     = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sample_extremes();
        test_step_alarms();
        test_unused_register();
        test_random_streams();

        drain();
        repeat (60) @(posedge clk);
        mismatches += expected_words.size();

        $display("coverage: %0d sample words sent, %0d results checked, %0d register writes",
                 words_sent, words_checked, reg_writes);
        $display("coverage: %0d detector settings, %0d up and %0d down alarms seen",
                 settings_used, up_fired, down_fired);
        if (mismatches == 0)
            $display("[page_hinkley_drift_detector] OK");
        else
            $display("[page_hinkley_drift_detector] ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #40000000;
        $display("[page_hinkley_drift_detector] ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/phd_pkg.sv
rtl/phd_if.sv
rtl/phd_divider.sv
rtl/page_hinkley_drift_detector.sv
tb/sv/page_hinkley_drift_detector_tb.sv
